// File: design/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants for the full linear convolution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

   // Default sizing of the tap chain and sample width
   localparam int MAX_TAPS_DEF    = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths on the ports
   localparam int VALUE_W     = 16;
   localparam int RESULT_W    = 36;
   localparam int RSP_TDATA_W = 40;

   // Command codes carried in req_tuser
   localparam logic CMD_LOAD = 1'b0;   // load next tap
   localparam logic CMD_PUSH = 1'b1;   // push next sample

   // Per-cycle control broadcast to every cell of the chain
   typedef struct packed {
      logic step;    // shift one sample (or flush zero) through the chain
      logic clear;   // zero all partial sums
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: design/flc_cell.sv
// ----------------------------------------------------------------------------
// flc_cell
// One tap of the transposed-form convolution chain: holds its tap and the
// partial sum handed over by its right-hand neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_cell #(
   parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  flc_pkg::cell_ctrl_type           ctrl,
   input  wire                              tap_we,
   input  wire  signed [SAMPLE_BITS-1:0]    tap_in,
   input  wire                              active,
   input  wire  signed [SAMPLE_BITS-1:0]    x,
   input  wire         [flc_pkg::RESULT_W-1:0] sum_nxt,
   output logic        [flc_pkg::RESULT_W-1:0] sum_out
);

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int EW = (PW > flc_pkg::RESULT_W) ? PW : flc_pkg::RESULT_W;

   logic signed [SAMPLE_BITS-1:0]       tap_ff;
   logic        [flc_pkg::RESULT_W-1:0] acc_ff;
   logic        [flc_pkg::RESULT_W-1:0] acc_in;
   logic signed [PW-1:0]                prod;
   logic signed [EW-1:0]                prod_ext;

   // Tap register, written once per tap set
   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_ff <= tap_in;
      end
   end

   // Partial sum taken from the neighbor on each step
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.step) begin
         acc_in = sum_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Multiply-add; sums wrap modulo the result width
   assign prod     = tap_ff * x;
   assign prod_ext = EW'(prod);
   assign sum_out  = active ? (prod_ext[flc_pkg::RESULT_W-1:0] + acc_ff) : '0;

endmodule

`default_nettype wire

// File: design/full_linear_convolution_unit.sv
// ----------------------------------------------------------------------------
// full_linear_convolution_unit
// Streaming full linear convolution built as a chain of multiply-add cells.
// ----------------------------------------------------------------------------
// Load the second sequence first as taps (req_tuser = load, req_tlast on the
// final tap; taps beyond MAX_TAPS are dropped), then stream the first
// sequence (req_tuser = push). Each sample gives one result; the sample
// marked last is followed by a flush (N = taps loaded) in which req_tready is
// low and the remaining N-1 results come out, the final one with rsp_tlast.
// A run of S samples thus gives S + N - 1 results. The tap chain sets the
// rate: every cell does one multiply-add per cycle while the result side
// does not stall, and the result is registered once at the output. Results
// are signed Q6.30 in 36 bits and never saturate. Pushes before the tap set
// is closed are taken and dropped. The taps stay loaded for further runs; a
// tap load after a closed set starts a new one.
`default_nettype none

module full_linear_convolution_unit #(
   parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [flc_pkg::VALUE_W-1:0]          req_tdata,   // [15:0] value
   input  wire                                  req_tuser,   // [0] cmd
   input  wire                                  req_tlast,   // last
   // result stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [flc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // [35:0] result, rest zero
   output logic                                 rsp_tlast    // last_res
);

   localparam int CW = $clog2(MAX_TAPS + 1);

   logic [CW-1:0]  tap_count_ff, tap_count_in;
   logic           taps_complete_ff, taps_complete_in;
   logic [CW-1:0]  flush_rem_ff, flush_rem_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [flc_pkg::RESULT_W-1:0] rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;

   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] x_bus;
   logic           flushing, can_adv, accepted, is_load, is_push, flush_step;
   logic [CW-1:0]  wr_idx;
   logic           wr_en;
   flc_pkg::cell_ctrl_type ctrl;
   logic [flc_pkg::RESULT_W-1:0] chain [MAX_TAPS+1];

   // Sample taken from the value field
   generate
      if (SAMPLE_BITS <= flc_pkg::VALUE_W) begin : g_narrow
         assign sample = req_tdata[SAMPLE_BITS-1:0];
      end else begin : g_wide
         assign sample = {{(SAMPLE_BITS-flc_pkg::VALUE_W){1'b0}}, req_tdata};
      end
   endgenerate

   // Handshake and step decode
   assign flushing   = (flush_rem_ff != '0);
   assign can_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !flushing && can_adv;
   assign accepted   = req_tvalid && req_tready;
   assign is_load    = accepted && (req_tuser == flc_pkg::CMD_LOAD);
   assign is_push    = accepted && (req_tuser == flc_pkg::CMD_PUSH)
                       && taps_complete_ff && (tap_count_ff != '0);
   assign flush_step = flushing && can_adv;

   assign ctrl.step  = is_push || flush_step;
   assign ctrl.clear = (is_load && taps_complete_ff)
                       || (flush_step && (flush_rem_ff == CW'(1)));
   assign x_bus      = flushing ? '0 : sample;

   // Tap write position; a closed set restarts at zero
   assign wr_idx = taps_complete_ff ? '0 : tap_count_ff;
   assign wr_en  = is_load && (wr_idx < CW'(MAX_TAPS));

   // Next-state logic for control and output register
   always_comb begin
      tap_count_in     = tap_count_ff;
      taps_complete_in = taps_complete_ff;
      flush_rem_in     = flush_rem_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;

      if (is_load) begin
         tap_count_in     = wr_en ? (wr_idx + CW'(1)) : wr_idx;
         taps_complete_in = req_tlast;
      end

      if (is_push && req_tlast) begin
         flush_rem_in = tap_count_ff - CW'(1);
      end else if (flush_step) begin
         flush_rem_in = flush_rem_ff - CW'(1);
      end

      if (ctrl.step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chain[0];
         rsp_last_in  = flushing ? (flush_rem_ff == CW'(1))
                                 : (req_tlast && (tap_count_ff == CW'(1)));
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= '0;
         taps_complete_ff <= 1'b0;
         flush_rem_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         tap_count_ff     <= tap_count_in;
         taps_complete_ff <= taps_complete_in;
         flush_rem_ff     <= flush_rem_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Chain of cells; partial sums move toward cell 0
   assign chain[MAX_TAPS] = '0;

   generate
      for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
         flc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .tap_we  (wr_en && (wr_idx == CW'(j))),
            .tap_in  (sample),
            .active  (CW'(j) < tap_count_ff),
            .x       (x_bus),
            .sum_nxt (chain[j+1]),
            .sum_out (chain[j])
         );
      end
   endgenerate

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(flc_pkg::RSP_TDATA_W-flc_pkg::RESULT_W){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/flc_checker.sv
// ----------------------------------------------------------------------------
// flc_checker
// Port-level checks for the full linear convolution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire                               req_tuser,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [flc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire                               rsp_tlast
);

   // A stalled result holds its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input is held off while the result register is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   // A tap load with nothing pending makes no result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == flc_pkg::CMD_LOAD) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("tap load produced a result");

   // Guard bits above the result are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[flc_pkg::RSP_TDATA_W-1:flc_pkg::RESULT_W] == '0))
      else $error("padding bits not zero");

endmodule

bind full_linear_convolution_unit flc_checker u_flc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for full_linear_convolution_unit. Tap sets and
// sample runs are sent over the request stream. A scoreboard class keeps its
// own FIR model of the unit and checks every result transaction in order.
// Both stream sides idle at random. One long result stall backs up the
// request side, and one pause waits for the result side to drain.
// ----------------------------------------------------------------------------

module tb;

   localparam int TAP_DEPTH   = flc_pkg::MAX_TAPS_DEF;
   localparam int ITEM_TARGET = 300;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 50;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: FIR model of the unit plus an ordered store of the expected
   // results
   // -------------------------------------------------------------------------
   class conv_scoreboard;
      logic signed [flc_pkg::VALUE_W-1:0] tap_coef [TAP_DEPTH];
      logic signed [flc_pkg::VALUE_W-1:0] sample_window [TAP_DEPTH];
      int unsigned                        tap_cnt;
      bit                                 taps_closed;
      logic [flc_pkg::RESULT_W-1:0]       expected_sum_q [$];
      bit                                 expected_last_q [$];
      int                                 mismatches;
      int                                 results_checked;

      function new();
         for (int i = 0; i < TAP_DEPTH; i++) begin
            tap_coef[i]      = '0;
            sample_window[i] = '0;
         end
         tap_cnt         = 0;
         taps_closed     = 1'b0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      function int pending();
         return expected_sum_q.size();
      endfunction

      function void clear_window();
         for (int i = 0; i < TAP_DEPTH; i++) sample_window[i] = '0;
      endfunction

      // newest sample sits at index 0
      function void shift_window(logic signed [flc_pkg::VALUE_W-1:0] x);
         for (int i = TAP_DEPTH - 1; i > 0; i--) sample_window[i] = sample_window[i-1];
         sample_window[0] = x;
      endfunction

      function logic [flc_pkg::RESULT_W-1:0] window_sum();
         longint acc;
         acc = 0;
         for (int j = 0; j < tap_cnt; j++)
            acc += longint'(tap_coef[j]) * longint'(sample_window[j]);
         return acc[flc_pkg::RESULT_W-1:0];
      endfunction

      // Called for every accepted request transaction
      function void note_input(logic cmd, logic [flc_pkg::VALUE_W-1:0] value, logic last);
         if (cmd == flc_pkg::CMD_LOAD) begin
            // a load after a closed set starts a new set
            if (taps_closed) begin
               tap_cnt     = 0;
               taps_closed = 1'b0;
               clear_window();
            end
            // taps past the chain depth are dropped
            if (tap_cnt < TAP_DEPTH) begin
               tap_coef[tap_cnt] = value;
               tap_cnt++;
            end
            if (last) taps_closed = 1'b1;
            return;
         end
         // samples with no closed tap set are dropped
         if (!taps_closed || tap_cnt == 0) return;
         shift_window(value);
         expected_sum_q.push_back(window_sum());
         expected_last_q.push_back(last && tap_cnt == 1);
         if (last) begin
            // flush the chain with zeros
            for (int k = 1; k < tap_cnt; k++) begin
               shift_window('0);
               expected_sum_q.push_back(window_sum());
               expected_last_q.push_back(k + 1 == tap_cnt);
            end
            clear_window();
         end
      endfunction

      // Called for every accepted result transaction
      function void check_result(logic [flc_pkg::RESULT_W-1:0] sum, logic last);
         logic [flc_pkg::RESULT_W-1:0] exp_sum;
         bit                           exp_last;
         results_checked++;
         if (expected_sum_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("ERROR: result with none outstanding: sum %h last %b", sum, last);
            return;
         end
         exp_sum  = expected_sum_q.pop_front();
         exp_last = expected_last_q.pop_front();
         if (sum !== exp_sum || last !== exp_last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("ERROR: result %0d: expected sum %h last %b, got sum %h last %b",
                        results_checked, exp_sum, exp_last, sum, last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [flc_pkg::VALUE_W-1:0]     req_tdata;
   logic                            req_tuser;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [flc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;

   conv_scoreboard sb;
   bit             no_idle;
   bit             hold_rsp_req;
   int             cycle_cnt;
   int             n_items;
   int             n_tap_sets;
   int             n_runs;

   always #6 clock = ~clock;

   full_linear_convolution_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] value
      .req_tuser  (req_tuser),    // [0] cmd
      .req_tlast  (req_tlast),    // last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [35:0] result, rest zero
      .rsp_tlast  (rsp_tlast)     // last_res
   );

   // -------------------------------------------------------------------------
   // Run limit
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, sb.pending());
         $display("full_linear_convolution_unit regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side: check accepted transactions, random back-pressure, one
   // long hold when asked for
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[flc_pkg::RESULT_W-1:0], rsp_tlast);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 25);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // One request transaction, with random idle cycles ahead of it
   task automatic send_item(input logic cmd, input logic [flc_pkg::VALUE_W-1:0] value,
                            input logic last);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= cmd;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_input(cmd, value, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Values lean toward the corners of the Q1.15 range
   function automatic logic [flc_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return flc_pkg::VALUE_W'($urandom());
      endcase
   endfunction

   initial begin : req_side
      int  n_taps;
      int  n_runs_here;
      int  n_samp;
      bit  extreme;
      bit  broken;
      bit  hold_done;
      bit  pause_done;
      logic [flc_pkg::VALUE_W-1:0] v;

      sb           = new();
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = flc_pkg::CMD_LOAD;
      req_tlast    = 1'b0;
      no_idle      = 1'b0;
      hold_rsp_req = 1'b0;
      cycle_cnt    = 0;
      n_items      = 0;
      n_tap_sets   = 0;
      n_runs       = 0;
      hold_done    = 1'b0;
      pause_done   = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: sample with no taps, push before the set closes, corner
      // values, a second run on the same taps, a single tap, and a new set
      // loaded in the middle of a run
      send_item(flc_pkg::CMD_PUSH, 16'h7FFF, 1'b1);
      send_item(flc_pkg::CMD_LOAD, 16'h7FFF, 1'b0);
      send_item(flc_pkg::CMD_LOAD, 16'h8000, 1'b0);
      send_item(flc_pkg::CMD_PUSH, 16'h1234, 1'b0);
      send_item(flc_pkg::CMD_LOAD, 16'hFFFF, 1'b1);
      send_item(flc_pkg::CMD_PUSH, 16'h8000, 1'b0);
      send_item(flc_pkg::CMD_PUSH, 16'h7FFF, 1'b0);
      send_item(flc_pkg::CMD_PUSH, 16'h8000, 1'b1);
      send_item(flc_pkg::CMD_PUSH, 16'h8000, 1'b1);
      send_item(flc_pkg::CMD_LOAD, 16'h8000, 1'b1);
      send_item(flc_pkg::CMD_PUSH, 16'h8000, 1'b0);
      send_item(flc_pkg::CMD_PUSH, 16'h7FFF, 1'b1);
      send_item(flc_pkg::CMD_LOAD, 16'h0001, 1'b0);
      send_item(flc_pkg::CMD_LOAD, 16'h0000, 1'b1);
      send_item(flc_pkg::CMD_PUSH, 16'h5555, 1'b0);
      send_item(flc_pkg::CMD_LOAD, 16'hAAAA, 1'b1);
      send_item(flc_pkg::CMD_PUSH, 16'h0000, 1'b1);
      n_tap_sets = 4;
      n_runs     = 4;
      wait_drained();

      // Random: tap sets followed by a few sample runs
      while (n_items < ITEM_TARGET) begin
         if (n_tap_sets == 4)
            n_taps = TAP_DEPTH + 2;   // over-length set first
         else if ($urandom_range(19) == 0)
            n_taps = $urandom_range(TAP_DEPTH + 4, TAP_DEPTH + 1);
         else if ($urandom_range(5) == 0)
            n_taps = $urandom_range(TAP_DEPTH, 7);
         else
            n_taps = $urandom_range(6, 1);
         extreme = ($urandom_range(11) == 0);
         n_tap_sets++;

         for (int k = 0; k < n_taps; k++) begin
            // noise: a sample ahead of a tap load, with the set still open unless k is 0
            if ($urandom_range(7) == 0) begin
               send_item(flc_pkg::CMD_PUSH, pick_value(), 1'($urandom_range(1)));
            end
            v = extreme ? 16'h8000 : pick_value();
            send_item(flc_pkg::CMD_LOAD, v, k == n_taps - 1);
            n_items++;
         end

         n_runs_here = $urandom_range(3, 1);
         for (int r = 0; r < n_runs_here; r++) begin
            if (!hold_done && n_items >= 60) begin
               hold_done    = 1'b1;
               hold_rsp_req = 1'b1;
            end
            no_idle = (n_items >= 120 && n_items < 180);
            n_samp  = $urandom_range(8, 1);
            broken  = ($urandom_range(9) == 0);
            n_runs++;
            for (int s = 0; s < n_samp; s++) begin
               v = extreme ? 16'h8000 : pick_value();
               send_item(flc_pkg::CMD_PUSH, v, (s == n_samp - 1) && !broken);
               n_items++;
            end
            if (broken) break;   // next tap load cuts the run short
         end

         if (!pause_done && n_items >= 220) begin
            pause_done = 1'b1;
            wait_drained();
         end
      end

      // Drain and report
      no_idle = 1'b0;
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d tap sets and %0d sample runs; %0d results checked.",
               n_tap_sets, n_runs, sb.results_checked);
      $display("Included empty and open tap sets, over-length sets, a long result stall.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("full_linear_convolution_unit regression: pass");
      end else begin
         $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
         $display("full_linear_convolution_unit regression: fail");
      end
      $finish;
   end

endmodule
